// ===== sv/sptq_pkg.sv =====
// types, constants and compare function shared by the timer queue
package sptq_pkg;

  localparam int unsigned QUEUE_DEPTH           = 16;
  localparam int unsigned MAX_FIRES_PER_SERVICE = 32;
  localparam int unsigned RESULT_LIMIT          = 32;
  localparam int unsigned FIRE_LIMIT            =
    (MAX_FIRES_PER_SERVICE < RESULT_LIMIT) ? MAX_FIRES_PER_SERVICE : RESULT_LIMIT;

  localparam int unsigned IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned OCC_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CNT_W    = $clog2(FIRE_LIMIT + 1);
  localparam int unsigned NEXT_IDX = (QUEUE_DEPTH > 1) ? 1 : 0;

  localparam int unsigned S_TDATA_W = 104;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 3;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_SERVICE = 2'd1,
    CMD_PEEK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FIRED    = 3'd2,
    ST_NONE_DUE = 3'd3,
    ST_HEAD_DUE = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_FIRE,
    S_WALK,
    S_LAST
  } state_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INS,
    OP_DROP,
    OP_HEAD
  } arr_op_e;

  typedef struct packed {
    logic [31:0] dl;
    logic [7:0]  id;
    logic [31:0] per;
  } entry_t;

  // wrap-aware ordering of two deadlines
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    earlier = (a < b) || (!b[31] && a[31]);
  endfunction

endpackage

// ===== sv/sorted_periodic_timer_queue.sv =====
// sorted periodic timer queue: sequencer, entry row, shared adder and comparator
// an add is answered after the insert walk over the entry row has placed the new timer
// peek, clear and a refused add are answered from the decide state; service checks and fires
// each due timer in turn, plus an insert walk for each periodic timer that is re-sorted
// one transfer is taken at a time; the next is accepted after the last result is registered
// reset empties the queue; entry contents are left unset
module sorted_periodic_timer_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // now, offset_ticks, timer_id, interval_ticks
  input  logic [sptq_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // cmd
  input  logic [sptq_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // fired_id, deadline
  output logic [sptq_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // status
  output logic [sptq_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,
  output logic                             m_axis_tlast_o
);
  import sptq_pkg::*;

  state_e           state_q, state_d;
  cmd_e             cmd_q;
  logic [31:0]      now_q, off_q, per_in_q;
  logic [7:0]       tid_q;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  entry_t           ins_q, ins_d;
  entry_t           ent_q [QUEUE_DEPTH];
  status_e          pend_st_q, pend_st_d;
  logic [7:0]       pend_id_q, pend_id_d;
  logic [31:0]      pend_dl_q, pend_dl_d;
  logic             have_pend_q, have_pend_d;
  arr_op_e          arr_op;

  logic             m_valid_q, m_last_q;
  status_e          m_st_q;
  logic [7:0]       m_id_q;
  logic [31:0]      m_dl_q;
  logic             out_load, out_last, out_free;
  status_e          out_st;
  logic [7:0]       out_id;
  logic [31:0]      out_dl;

  logic [31:0]      add_a, add_b, sum;
  logic [31:0]      cmp_a, cmp_b;
  logic             lt;
  entry_t           rd_ent;
  logic             s_accept;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign rd_ent          = ent_q[idx_q[IDX_W-1:0]];

  // shared adder
  always_comb begin
    if (state_q == S_DECIDE) begin
      add_a = now_q;
      add_b = off_q;
    end else begin
      add_a = ent_q[0].dl;
      add_b = ent_q[0].per;
    end
    sum = add_a + add_b;
  end

  // shared comparator
  always_comb begin
    case (state_q)
      S_FIRE: begin
        cmp_a = ent_q[NEXT_IDX].dl;
        cmp_b = sum;
      end
      S_WALK: begin
        cmp_a = rd_ent.dl;
        cmp_b = ins_q.dl;
      end
      default: begin
        cmp_a = now_q;
        cmp_b = ent_q[0].dl;
      end
    endcase
    lt = earlier(cmp_a, cmp_b);
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    occ_d       = occ_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    ins_d       = ins_q;
    pend_st_d   = pend_st_q;
    pend_id_d   = pend_id_q;
    pend_dl_d   = pend_dl_q;
    have_pend_d = have_pend_q;
    arr_op      = OP_NONE;
    out_load    = 1'b0;
    out_last    = 1'b1;
    out_st      = ST_NONE_DUE;
    out_id      = '0;
    out_dl      = '0;
    case (state_q)
      S_IDLE: begin
        if (s_accept) begin
          state_d     = S_DECIDE;
          cnt_d       = '0;
          have_pend_d = 1'b0;
        end
      end
      S_DECIDE: begin
        case (cmd_q)
          CMD_ADD: begin
            if (occ_q == OCC_W'(QUEUE_DEPTH)) begin
              if (out_free) begin
                out_load = 1'b1;
                out_st   = ST_FULL;
                state_d  = S_IDLE;
              end
            end else begin
              ins_d     = '{dl: sum, id: tid_q, per: per_in_q};
              idx_d     = '0;
              pend_st_d = ST_ADDED;
              pend_id_d = tid_q;
              pend_dl_d = sum;
              state_d   = S_WALK;
            end
          end
          CMD_SERVICE: begin
            state_d = S_CHECK;
          end
          CMD_PEEK: begin
            if (out_free) begin
              out_load = 1'b1;
              out_st   = (occ_q != '0 && !lt) ? ST_HEAD_DUE : ST_NONE_DUE;
              state_d  = S_IDLE;
            end
          end
          default: begin
            if (out_free) begin
              occ_d    = '0;
              out_load = 1'b1;
              out_st   = ST_CLEARED;
              state_d  = S_IDLE;
            end
          end
        endcase
      end
      S_CHECK: begin
        if (out_free) begin
          if (cnt_q < CNT_W'(FIRE_LIMIT) && occ_q != '0 && !lt) begin
            out_load    = have_pend_q;
            out_last    = 1'b0;
            out_st      = pend_st_q;
            out_id      = pend_id_q;
            out_dl      = pend_dl_q;
            pend_st_d   = ST_FIRED;
            pend_id_d   = ent_q[0].id;
            pend_dl_d   = ent_q[0].dl;
            have_pend_d = 1'b1;
            cnt_d       = cnt_q + CNT_W'(1);
            state_d     = S_FIRE;
          end else begin
            out_load = 1'b1;
            if (have_pend_q) begin
              out_st = pend_st_q;
              out_id = pend_id_q;
              out_dl = pend_dl_q;
            end
            state_d = S_IDLE;
          end
        end
      end
      S_FIRE: begin
        if (ent_q[0].per == '0) begin
          arr_op  = OP_DROP;
          occ_d   = occ_q - OCC_W'(1);
          state_d = S_CHECK;
        end else if (occ_q > OCC_W'(1) && lt) begin
          arr_op  = OP_DROP;
          occ_d   = occ_q - OCC_W'(1);
          ins_d   = '{dl: sum, id: ent_q[0].id, per: ent_q[0].per};
          idx_d   = '0;
          state_d = S_WALK;
        end else begin
          arr_op  = OP_HEAD;
          state_d = S_CHECK;
        end
      end
      S_WALK: begin
        if (idx_q == occ_q || !lt) begin
          arr_op  = OP_INS;
          occ_d   = occ_q + OCC_W'(1);
          state_d = (cmd_q == CMD_ADD) ? S_LAST : S_CHECK;
        end else begin
          idx_d = idx_q + OCC_W'(1);
        end
      end
      S_LAST: begin
        if (out_free) begin
          out_load = 1'b1;
          out_st   = pend_st_q;
          out_id   = pend_id_q;
          out_dl   = pend_dl_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      have_pend_q <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      have_pend_q <= have_pend_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      cmd_q    <= cmd_e'(s_axis_tuser_i[1:0]);
      now_q    <= s_axis_tdata_i[31:0];
      off_q    <= s_axis_tdata_i[63:32];
      tid_q    <= s_axis_tdata_i[71:64];
      per_in_q <= s_axis_tdata_i[103:72];
    end
    ins_q     <= ins_d;
    pend_st_q <= pend_st_d;
    pend_id_q <= pend_id_d;
    pend_dl_q <= pend_dl_d;
    if (out_load) begin
      m_st_q   <= out_st;
      m_id_q   <= out_id;
      m_dl_q   <= out_dl;
      m_last_q <= out_last;
    end
  end

  // entry row: each entry takes its neighbor, the new timer, or the reloaded head
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_ent
    entry_t prv, nxt;
    if (g == 0) begin : g_first
      assign prv = '0;
    end else begin : g_prv
      assign prv = ent_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_end
      assign nxt = '0;
    end else begin : g_nxt
      assign nxt = ent_q[g+1];
    end
    always_ff @(posedge clk_i) begin
      case (arr_op)
        OP_INS: begin
          if (OCC_W'(g) == idx_q) begin
            ent_q[g] <= ins_q;
          end else if (OCC_W'(g) > idx_q) begin
            ent_q[g] <= prv;
          end
        end
        OP_DROP: begin
          ent_q[g] <= nxt;
        end
        OP_HEAD: begin
          if (g == 0) begin
            ent_q[g].dl <= sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {m_dl_q, m_id_q};
  assign m_axis_tuser_o  = m_st_q;
  assign m_axis_tlast_o  = m_last_q;

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(QUEUE_DEPTH))
    else $error("occupancy beyond queue depth");

  a_fire_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIRE_LIMIT))
    else $error("fire count beyond limit");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_free)
    else $error("pending result overwritten");

  a_walk_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WALK |-> idx_q <= occ_q && occ_q < OCC_W'(QUEUE_DEPTH))
    else $error("insert walk out of range");

  a_add_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LAST && out_free) |=> state_q == S_IDLE && m_valid_q && m_last_q)
    else $error("add result not final");

endmodule

// ===== sim/tb.sv =====
// testbench for the sorted periodic timer queue: directed and random commands checked per transfer
`timescale 1ns / 100ps

module tb;
  import sptq_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL     = 64;
  localparam int STALL_CYCLES   = 400;

  typedef struct {
    status_e     st;
    logic [7:0]  id;
    logic [31:0] dl;
    logic        last;
  } timer_result_t;

  logic                 clk;
  logic                 rst_n   = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data  = '0;
  logic [S_TUSER_W-1:0] s_user  = '0;
  logic                 m_ready = 1'b0;
  logic                 s_ready;
  logic                 m_valid;
  logic [M_TDATA_W-1:0] m_data;
  logic [M_TUSER_W-1:0] m_user;
  logic                 m_last;

  // predicted queue contents
  logic [31:0] q_dl  [QUEUE_DEPTH];
  logic [7:0]  q_id  [QUEUE_DEPTH];
  logic [31:0] q_per [QUEUE_DEPTH];
  int          q_count;

  timer_result_t awaited_results[$];
  int            mismatches;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            stall_start;
  int            stall_left;
  int            quiet_cycles;
  logic [31:0]   tick_now;

  sorted_periodic_timer_queue dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // now, offset_ticks, timer_id, interval_ticks
    .s_axis_tuser_i  (s_user),   // cmd
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // fired_id, deadline
    .m_axis_tuser_o  (m_user),   // status
    .m_axis_tlast_o  (m_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic bit wraps_before(logic [31:0] a, logic [31:0] b);
    return (a < b) || (!b[31] && a[31]);
  endfunction

  function automatic bit is_due(logic [31:0] dl, logic [31:0] at);
    return !wraps_before(at, dl);
  endfunction

  function automatic void sorted_insert(logic [31:0] dl, logic [7:0] id, logic [31:0] per);
    int pos;
    int k;
    if (q_count >= QUEUE_DEPTH) return;
    if (q_count == 0 || is_due(dl, q_dl[0])) begin
      pos = 0;
    end else begin
      k = 0;
      while (k + 1 < q_count && wraps_before(q_dl[k+1], dl)) k++;
      pos = k + 1;
    end
    for (int i = q_count; i > pos; i--) begin
      q_dl[i]  = q_dl[i-1];
      q_id[i]  = q_id[i-1];
      q_per[i] = q_per[i-1];
    end
    q_dl[pos]  = dl;
    q_id[pos]  = id;
    q_per[pos] = per;
    q_count++;
  endfunction

  function automatic void drop_head();
    if (q_count == 0) return;
    for (int i = 1; i < q_count; i++) begin
      q_dl[i-1]  = q_dl[i];
      q_id[i-1]  = q_id[i];
      q_per[i-1] = q_per[i];
    end
    q_count--;
  endfunction

  function automatic void await_result(status_e st, logic [7:0] id, logic [31:0] dl);
    timer_result_t r;
    r.st   = st;
    r.id   = id;
    r.dl   = dl;
    r.last = 1'b0;
    awaited_results.push_back(r);
  endfunction

  function automatic void predict_command(cmd_e cmd, logic [31:0] now, logic [31:0] offs,
                                          logic [7:0] id, logic [31:0] per);
    int          fires;
    logic [31:0] dl;
    logic [31:0] nd;
    logic [31:0] p;
    logic [7:0]  hid;
    case (cmd)
      CMD_ADD: begin
        if (q_count >= QUEUE_DEPTH) begin
          await_result(ST_FULL, 8'd0, 32'd0);
        end else begin
          dl = now + offs;
          sorted_insert(dl, id, per);
          await_result(ST_ADDED, id, dl);
        end
      end
      CMD_SERVICE: begin
        fires = 0;
        while (fires < FIRE_LIMIT && q_count > 0 && is_due(q_dl[0], now)) begin
          dl  = q_dl[0];
          hid = q_id[0];
          p   = q_per[0];
          await_result(ST_FIRED, hid, dl);
          fires++;
          if (p != 0) begin
            nd      = dl + p;
            q_dl[0] = nd;
            if (q_count > 1 && wraps_before(q_dl[1], nd)) begin
              drop_head();
              sorted_insert(nd, hid, p);
            end
          end else begin
            drop_head();
          end
        end
        if (fires == 0) await_result(ST_NONE_DUE, 8'd0, 32'd0);
      end
      CMD_PEEK: begin
        if (q_count > 0 && is_due(q_dl[0], now)) await_result(ST_HEAD_DUE, 8'd0, 32'd0);
        else await_result(ST_NONE_DUE, 8'd0, 32'd0);
      end
      default: begin
        q_count = 0;
        await_result(ST_CLEARED, 8'd0, 32'd0);
      end
    endcase
    awaited_results[awaited_results.size()-1].last = 1'b1;
  endfunction

  task automatic send_command(cmd_e cmd, logic [31:0] now, logic [31:0] offs,
                              logic [7:0] id, logic [31:0] per);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= cmd;
    s_data  <= {per, id, offs, now};
    do @(posedge clk); while (!s_ready);
    predict_command(cmd, now, offs, id, per);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  task automatic send_random_command();
    int          pick;
    cmd_e        cmd;
    logic [31:0] now;
    logic [31:0] offs;
    logic [31:0] per;
    logic [7:0]  id;
    pick = $urandom_range(99);
    id   = 8'($urandom_range(255));
    offs = ($urandom_range(9) == 0) ? $urandom : $urandom_range(150);
    case ($urandom_range(9))
      0, 1, 2: per = 32'd0;
      3, 4:    per = $urandom;
      default: per = $urandom_range(1, 80);
    endcase
    if (pick < 45) begin
      cmd      = CMD_ADD;
      tick_now = tick_now + $urandom_range(20);
    end else if (pick < 80) begin
      cmd      = CMD_SERVICE;
      tick_now = tick_now + $urandom_range(80);
    end else if (pick < 93) begin
      cmd      = CMD_PEEK;
      tick_now = tick_now + $urandom_range(40);
    end else if (pick < 96) begin
      cmd = CMD_CLEAR;
    end else begin
      cmd = cmd_e'($urandom_range(3));
      if ($urandom_range(1)) tick_now = $urandom;
      else begin
        send_command(cmd, $urandom, $urandom, id, $urandom);
        return;
      end
    end
    now = tick_now;
    send_command(cmd, now, offs, id, per);
  endtask

  task automatic test_empty_queue();
    send_command(CMD_PEEK, 32'd0, 32'd0, 8'd0, 32'd0);
    send_command(CMD_SERVICE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // wrapped deadlines, ties ahead of equal entries, peek either side of the head
  task automatic test_wrap_and_ties();
    send_command(CMD_ADD, 32'hFFFF_FFF0, 32'h20, 8'd1, 32'd0);
    send_command(CMD_ADD, 32'hFFFF_FFF0, 32'd0, 8'd2, 32'hFFFF_FFFF);
    send_command(CMD_ADD, 32'd0, 32'h10, 8'd3, 32'd0);
    send_command(CMD_PEEK, 32'hFFFF_FFEF, 32'd0, 8'd0, 32'd0);
    send_command(CMD_PEEK, 32'hFFFF_FFF0, 32'd0, 8'd0, 32'd0);
    send_command(CMD_SERVICE, 32'h10, 32'd0, 8'd0, 32'd0);
    send_command(CMD_ADD, 32'd1, 32'hFFFF_FFFF, 8'hFF, 32'h8000_0000);
  endtask

  // full queue refuses an add; periodic timers all due hit the fire bound
  task automatic test_full_and_fire_bound();
    send_command(CMD_CLEAR, 32'd0, 32'd0, 8'd0, 32'd0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      send_command(CMD_ADD, 32'd100, 32'd0, 8'(i * 17), 32'd1);
    send_command(CMD_ADD, 32'd100, 32'd5, 8'h5A, 32'd0);
    send_command(CMD_SERVICE, 32'd1000, 32'd0, 8'd0, 32'd0);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < count; i++) send_random_command();
  endtask

  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_start   = STALL_CYCLES;
    for (int i = 0; i < 20; i++) send_random_command();
  endtask

  task automatic drain_results();
    s_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_start != 0) begin
      stall_left  = stall_start;
      stall_start = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_output
    timer_result_t want;
    if (rst_n && m_valid && m_ready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("unexpected result", m_data[39:8], 32'd0);
      end else begin
        want = awaited_results.pop_front();
        if (m_user !== want.st) report_mismatch("status", 32'(m_user), 32'(want.st));
        if (m_data[7:0] !== want.id)
          report_mismatch("fired_id", 32'(m_data[7:0]), 32'(want.id));
        if (m_data[39:8] !== want.dl) report_mismatch("deadline", m_data[39:8], want.dl);
        if (m_last !== want.last) report_mismatch("last", 32'(m_last), 32'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_valid && s_ready) || (m_valid && m_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    mismatches    = 0;
    send_idle_pct = 9;
    recv_idle_pct = 56;
    stall_start   = 0;
    stall_left    = 0;
    quiet_cycles  = 0;
    q_count       = 0;
    tick_now      = 32'hFFFF_FE00;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_queue();
    test_wrap_and_ties();
    test_full_and_fire_bound();
    test_random(150, 9, 56);
    test_random(150, 56, 9);
    test_random(140, 0, 0);
    test_output_stall();
    drain_results();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
